@@ hw/rtl/srs_pkg.sv @@
package srs_pkg;

	localparam int DEF_NUM_SETS       = 2048;
	localparam int DEF_NUM_WAYS       = 16;
	localparam int DEF_RRPV_WIDTH     = 2;
	localparam int DEF_SIG_WIDTH      = 10;
	localparam int DEF_COUNTER_WIDTH  = 3;
	localparam int DEF_STREAM_ENTRIES = 1024;

	localparam int BLK_W    = 42;
	localparam int STRIDE_W = 43;
	localparam int REP_W    = 2;
	// valid, last block, last stride, repeat count
	localparam int STREAM_W = 1 + BLK_W + STRIDE_W + REP_W;

	localparam int PADDR_W = 3;

	// register decode on the word address bit
	localparam logic REG_REUSE_THRESHOLD    = 1'b0;
	localparam logic REG_STREAM_MIN_REPEATS = 1'b1;

	localparam logic [2:0] THRESH_RESET  = 3'd3;
	localparam logic [1:0] MINREP_RESET  = 2'd2;
	localparam logic [1:0] REP_SAT       = 2'd3;

	typedef struct packed {
		logic clr;
		logic load;
		logic calc;
		logic rd;
		logic ex1;
		logic ex2;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic miss_fill;
	} status_t;

endpackage

@@ hw/rtl/srs_ram.sv @@
module srs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/srs_ctrl.sv @@
module srs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  srs_pkg::status_t status,
	output srs_pkg::cmd_t    cmd,
	output logic             busy
);

	import srs_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CLR  = 3'd1;
	localparam logic [2:0] S_IDX  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_EX1  = 3'd4;
	localparam logic [2:0] S_EX2  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR: begin
				if (status.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) state_d = S_IDX;
			end
			S_IDX: state_d = S_RD;
			S_RD:  state_d = S_EX1;
			S_EX1: begin
				state_d = status.miss_fill ? S_EX2 : S_IDLE;
			end
			S_EX2: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign cmd.clr  = (state_q == S_CLR);
	assign cmd.load = (state_q == S_IDLE) && start;
	assign cmd.calc = (state_q == S_IDX);
	assign cmd.rd   = (state_q == S_RD);
	assign cmd.ex1  = (state_q == S_EX1);
	assign cmd.ex2  = (state_q == S_EX2);
	assign cmd.emit = ((state_q == S_EX1) && !status.miss_fill) || (state_q == S_EX2);

	a_emit_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (state_q == S_EX1 || state_q == S_EX2))
		else $error("result emitted outside execute");

	a_ex2_after_ex1: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EX2) |-> ($past(state_q) == S_EX1 && $past(status.miss_fill)))
		else $error("second execute cycle without a miss fill");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |=> (state_q == S_CLR || state_q == S_IDLE))
		else $error("transaction started during clearing pass");

endmodule

@@ hw/rtl/srs_dp.sv @@
module srs_dp #(
	parameter int NUM_SETS       = srs_pkg::DEF_NUM_SETS,
	parameter int NUM_WAYS       = srs_pkg::DEF_NUM_WAYS,
	parameter int RRPV_WIDTH     = srs_pkg::DEF_RRPV_WIDTH,
	parameter int SIG_WIDTH      = srs_pkg::DEF_SIG_WIDTH,
	parameter int COUNTER_WIDTH  = srs_pkg::DEF_COUNTER_WIDTH,
	parameter int STREAM_ENTRIES = srs_pkg::DEF_STREAM_ENTRIES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  srs_pkg::cmd_t    cmd,
	output srs_pkg::status_t status,
	input  logic             action,
	input  logic [10:0]      set_index,
	input  logic [3:0]       way,
	input  logic             hit,
	input  logic [11:0]      pc_low,
	input  logic [41:0]      block_address,
	input  logic [2:0]       reuse_threshold,
	input  logic [1:0]       stream_min_repeats,
	output logic             done,
	output logic [3:0]       victim_way,
	output logic             stream_seen,
	output logic             predicted_reuse
);

	import srs_pkg::*;

	localparam int LW      = RRPV_WIDTH + 1 + SIG_WIDTH;
	localparam int ROW_W   = NUM_WAYS * LW;
	localparam int SET_AW  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int STR_AW  = $clog2(STREAM_ENTRIES);
	localparam int SIG_CNT = 1 << SIG_WIDTH;
	localparam int WAY_W   = $clog2(NUM_WAYS);
	localparam int CLR_DEPTH_A = (NUM_SETS > SIG_CNT) ? NUM_SETS : SIG_CNT;
	localparam int CLR_DEPTH   = (CLR_DEPTH_A > STREAM_ENTRIES) ? CLR_DEPTH_A : STREAM_ENTRIES;
	localparam int CLR_W   = $clog2(CLR_DEPTH);
	localparam int SET_R   = (NUM_SETS >= 2048) ? 1 : ((1 << 22) + NUM_SETS - 1) / NUM_SETS;
	localparam int STR_R   = (STREAM_ENTRIES >= 1024) ? 1 :
		((1 << 20) + STREAM_ENTRIES - 1) / STREAM_ENTRIES;
	localparam logic [RRPV_WIDTH-1:0]    RRPV_TOP  = '1;
	localparam logic [RRPV_WIDTH-1:0]    RRPV_MID  = RRPV_TOP - 1'b1;
	localparam logic [COUNTER_WIDTH-1:0] CTR_TOP   = '1;
	localparam logic [COUNTER_WIDTH-1:0] CTR_START = CTR_TOP >> 1;

	// captured transaction
	logic              action_q;
	logic [10:0]       set_in_q;
	logic [3:0]        way_q;
	logic              hit_q;
	logic [11:0]       pc_q;
	logic [BLK_W-1:0]  blk_q;

	logic [10:0]       qset_q;
	logic [9:0]        qstr_q;
	logic [SET_AW-1:0] set_q;
	logic [STR_AW-1:0] sidx_q;
	logic [COUNTER_WIDTH-1:0] ctr_new_q;
	logic              seen_q;
	logic [CLR_W-1:0]  clr_addr_q;

	logic              done_q;
	logic [3:0]        victim_q;
	logic              seen_out_q;
	logic              pred_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			set_in_q <= set_index;
			way_q    <= way;
			hit_q    <= hit;
			pc_q     <= pc_low;
			blk_q    <= block_address;
		end
	end

	// quotient by reciprocal multiply, exact for these operand ranges
	logic [33:0] set_prod;
	logic [29:0] str_prod;
	assign set_prod = 34'(set_in_q) * 34'(SET_R);
	assign str_prod = 30'(pc_q[11:2]) * 30'(STR_R);

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			qset_q <= set_prod[32:22];
			qstr_q <= str_prod[29:20];
		end
	end

	logic [21:0]       set_back;
	logic [19:0]       str_back;
	logic [10:0]       set_rem;
	logic [9:0]        str_rem;
	logic [SET_AW-1:0] set_idx;
	logic [STR_AW-1:0] sidx;

	assign set_back = 22'(qset_q) * 22'(NUM_SETS);
	assign str_back = 20'(qstr_q) * 20'(STREAM_ENTRIES);
	assign set_rem  = set_in_q - set_back[10:0];
	assign str_rem  = pc_q[11:2] - str_back[9:0];
	assign set_idx  = (NUM_SETS >= 2048) ? SET_AW'(set_in_q) : SET_AW'(set_rem);
	assign sidx     = (STREAM_ENTRIES >= 1024) ? STR_AW'(pc_q[11:2]) : STR_AW'(str_rem);

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			set_q  <= set_idx;
			sidx_q <= sidx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	assign status.clr_done = (clr_addr_q == CLR_W'(CLR_DEPTH - 1));

	// memories
	logic                     row_we, row_re;
	logic [SET_AW-1:0]        row_waddr;
	logic [ROW_W-1:0]         row_wdata, row_rd;
	logic                     str_we, str_re;
	logic [STR_AW-1:0]        str_waddr;
	logic [STREAM_W-1:0]      str_wdata, str_rd;
	logic                     ctr_we, ctr_re;
	logic [SIG_WIDTH-1:0]     ctr_waddr, ctr_raddr;
	logic [COUNTER_WIDTH-1:0] ctr_wdata, ctr_rd;

	srs_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS), .AW(SET_AW)) u_row_ram (
		.clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
		.re(row_re), .raddr(set_idx), .rdata(row_rd)
	);

	srs_ram #(.WIDTH(STREAM_W), .DEPTH(STREAM_ENTRIES), .AW(STR_AW)) u_str_ram (
		.clk(clk), .we(str_we), .waddr(str_waddr), .wdata(str_wdata),
		.re(str_re), .raddr(sidx), .rdata(str_rd)
	);

	srs_ram #(.WIDTH(COUNTER_WIDTH), .DEPTH(SIG_CNT), .AW(SIG_WIDTH)) u_ctr_ram (
		.clk(clk), .we(ctr_we), .waddr(ctr_waddr), .wdata(ctr_wdata),
		.re(ctr_re), .raddr(ctr_raddr), .rdata(ctr_rd)
	);

	// decode of the captured update
	logic                 way_ok;
	logic [WAY_W-1:0]     wsel;
	logic [SIG_WIDTH-1:0] new_sig, old_sig;
	logic                 old_reused;

	assign way_ok     = (32'(way_q) < NUM_WAYS);
	assign wsel       = WAY_W'(way_q);
	assign new_sig    = SIG_WIDTH'(pc_q[11:2]);
	assign old_sig    = row_rd[32'(wsel) * LW + RRPV_WIDTH + 1 +: SIG_WIDTH];
	assign old_reused = row_rd[32'(wsel) * LW + RRPV_WIDTH];

	assign status.miss_fill = action_q && way_ok && !hit_q;

	// stream training
	logic [BLK_W-1:0]    st_last;
	logic [STRIDE_W-1:0] st_stride, stride;
	logic [REP_W-1:0]    st_rep, rep_new;
	logic [STRIDE_W-1:0] stride_new;
	logic                st_valid, seen;

	assign {st_valid, st_last, st_stride, st_rep} = str_rd;
	assign stride = {1'b0, blk_q} - {1'b0, st_last};

	always_comb begin
		stride_new = st_stride;
		rep_new    = st_rep;
		seen       = 1'b0;
		if (st_valid) begin
			if (stride == st_stride) begin
				if (st_rep != REP_SAT) rep_new = st_rep + 1'b1;
				seen = (rep_new >= stream_min_repeats);
			end else begin
				stride_new = stride;
				rep_new    = REP_W'(1);
			end
		end
	end

	// victim search over the set
	logic [(1 << RRPV_WIDTH)-1:0] present;
	logic [RRPV_WIDTH-1:0]        maxv, add;
	logic [WAY_W-1:0]             pick;
	logic [ROW_W-1:0]             row_aged;

	always_comb begin
		present = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			present[row_rd[w * LW +: RRPV_WIDTH]] = 1'b1;
		end
		maxv = '0;
		for (int v = 0; v < (1 << RRPV_WIDTH); v++) begin
			if (present[v]) maxv = RRPV_WIDTH'(v);
		end
		add  = RRPV_TOP - maxv;
		pick = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (row_rd[w * LW +: RRPV_WIDTH] == maxv) pick = WAY_W'(w);
		end
		row_aged = row_rd;
		for (int w = 0; w < NUM_WAYS; w++) begin
			row_aged[w * LW +: RRPV_WIDTH] = row_rd[w * LW +: RRPV_WIDTH] + add;
		end
	end

	// signature counter training and fill
	logic [COUNTER_WIDTH-1:0] ctr_old_new, ctr_sig;
	logic                     pred;
	logic [ROW_W-1:0]         row_init, row_hit, row_fill;

	always_comb begin
		ctr_old_new = ctr_rd;
		if (old_reused) begin
			if (ctr_rd != CTR_TOP) ctr_old_new = ctr_rd + 1'b1;
		end else begin
			if (ctr_rd != '0) ctr_old_new = ctr_rd - 1'b1;
		end
		ctr_sig = (old_sig == new_sig) ? ctr_old_new : ctr_new_q;
		pred    = (8'(ctr_sig) > 8'(reuse_threshold)) || seen_q;

		row_init = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			row_init[w * LW +: RRPV_WIDTH] = RRPV_MID;
		end
		row_hit = row_rd;
		row_hit[32'(wsel) * LW +: RRPV_WIDTH + 1] = {1'b1, {RRPV_WIDTH{1'b0}}};
		row_fill = row_rd;
		row_fill[32'(wsel) * LW +: LW] = {new_sig, 1'b0, pred ? RRPV_MID : RRPV_TOP};
	end

	always_comb begin
		row_re    = cmd.rd;
		str_re    = cmd.rd;
		ctr_re    = cmd.rd || cmd.ex1;
		ctr_raddr = cmd.rd ? new_sig : old_sig;

		row_we    = 1'b0;
		row_waddr = set_q;
		row_wdata = row_aged;
		str_we    = 1'b0;
		str_waddr = sidx_q;
		str_wdata = {1'b1, blk_q, stride_new, rep_new};
		ctr_we    = 1'b0;
		ctr_waddr = old_sig;
		ctr_wdata = ctr_old_new;

		if (cmd.clr) begin
			row_we    = (32'(clr_addr_q) < NUM_SETS);
			row_waddr = SET_AW'(clr_addr_q);
			row_wdata = row_init;
			str_we    = (32'(clr_addr_q) < STREAM_ENTRIES);
			str_waddr = STR_AW'(clr_addr_q);
			str_wdata = '0;
			ctr_we    = (32'(clr_addr_q) < SIG_CNT);
			ctr_waddr = SIG_WIDTH'(clr_addr_q);
			ctr_wdata = CTR_START;
		end else if (cmd.ex1) begin
			str_we = action_q;
			if (!action_q) begin
				row_we    = 1'b1;
				row_wdata = row_aged;
			end else if (way_ok && hit_q) begin
				row_we    = 1'b1;
				row_wdata = row_hit;
			end
		end else if (cmd.ex2) begin
			row_we    = 1'b1;
			row_wdata = row_fill;
			ctr_we    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ex1) begin
			ctr_new_q <= ctr_rd;
			seen_q    <= seen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			victim_q   <= action_q ? 4'd0 : 4'(pick);
			seen_out_q <= action_q && (cmd.ex2 ? seen_q : seen);
			pred_q     <= cmd.ex2 && pred;
		end
	end

	assign done            = done_q;
	assign victim_way      = victim_q;
	assign stream_seen     = seen_out_q;
	assign predicted_reuse = pred_q;

endmodule

@@ hw/rtl/ship_rrip_stream_replacement.sv @@
// Cache replacement engine: 2-bit SRRIP with a SHiP signature predictor and a
// per-PC stride stream detector. Pulse start while busy is low to hand over one
// transaction (victim query or access update); exactly one result comes back
// on done for a single cycle and must be taken then. A transaction passes the
// states index, read and execute, and done is registered from the last execute
// state; a miss fill adds a second execute state, since the evicted line's
// signature counter is read after the set row and written back in that state.
// busy drops as done rises, so the next transaction can be taken at the edge
// that ends the done cycle; a new transaction is not taken before the last
// one's result. Per-set line state, the signature counters and the stream table
// live in single-write RAMs with registered reads. After reset the block runs a
// clearing pass over every entry of these three tables with busy high; register
// writes are taken throughout.
module ship_rrip_stream_replacement #(
	parameter int NUM_SETS       = srs_pkg::DEF_NUM_SETS,
	parameter int NUM_WAYS       = srs_pkg::DEF_NUM_WAYS,
	parameter int RRPV_WIDTH     = srs_pkg::DEF_RRPV_WIDTH,
	parameter int SIG_WIDTH      = srs_pkg::DEF_SIG_WIDTH,
	parameter int COUNTER_WIDTH  = srs_pkg::DEF_COUNTER_WIDTH,
	parameter int STREAM_ENTRIES = srs_pkg::DEF_STREAM_ENTRIES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        action,
	input  logic [10:0]                 set_index,
	input  logic [3:0]                  way,
	input  logic                        hit,
	input  logic [11:0]                 pc_low,
	input  logic [41:0]                 block_address,
	output logic                        done,
	output logic [3:0]                  victim_way,
	output logic                        stream_seen,
	output logic                        predicted_reuse,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [srs_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	import srs_pkg::*;

	logic [2:0] thresh_q;
	logic [1:0] minrep_q;
	logic       wr_en;
	cmd_t       cmd;
	status_t    status;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
			minrep_q <= MINREP_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_REUSE_THRESHOLD:    thresh_q <= pwdata[2:0];
				REG_STREAM_MIN_REPEATS: minrep_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_REUSE_THRESHOLD:    prdata = {29'd0, thresh_q};
			REG_STREAM_MIN_REPEATS: prdata = {30'd0, minrep_q};
			default:                prdata = '0;
		endcase
	end

	srs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start),
		.status(status), .cmd(cmd), .busy(busy)
	);

	srs_dp #(
		.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .RRPV_WIDTH(RRPV_WIDTH),
		.SIG_WIDTH(SIG_WIDTH), .COUNTER_WIDTH(COUNTER_WIDTH),
		.STREAM_ENTRIES(STREAM_ENTRIES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.action(action), .set_index(set_index), .way(way), .hit(hit),
		.pc_low(pc_low), .block_address(block_address),
		.reuse_threshold(thresh_q), .stream_min_repeats(minrep_q),
		.done(done), .victim_way(victim_way), .stream_seen(stream_seen),
		.predicted_reuse(predicted_reuse)
	);

endmodule
